// ----- sv/dimuon_invariant_mass_histogram_core_defines.svh -----
// Assertion macros for the port-level checker file.
`ifndef DIMUON_INVARIANT_MASS_HISTOGRAM_CORE_DEFINES_SVH
`define DIMUON_INVARIANT_MASS_HISTOGRAM_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DIMU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dimu check failed");
// Next-cycle implication checked outside reset.
`define DIMU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dimu check failed");
`endif

// ----- sv/dimu_pkg.sv -----
// Package with types and constants of the dimuon mass histogram.
package dimu_pkg;
  localparam int unsigned MOM_W   = 20;
  localparam int unsigned MASS_W  = 21;
  localparam int unsigned BIN_W   = 7;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SQ_W    = 42;
  localparam int unsigned MAG_W   = 21;
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned IN_W    = 136;
  localparam int unsigned OUT_W   = 64;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [MASS_W-1:0] MASS_MAX = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MASS_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASS_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BINS      = 2'd2;

  // Request kinds.
  localparam logic FUNC_FILL = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CLEAR = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_SQRT  = 9'b000001000,
    ST_PROD  = 9'b000010000,
    ST_MSQRT = 9'b000100000,
    ST_DIV   = 9'b001000000,
    ST_RMW   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;
endpackage

// ----- sv/dimuon_invariant_mass_histogram_core.sv -----
// Dimuon invariant-mass histogram core: mass computation and binned counts.
// One request at a time. A read passes through the memory access and then the
// result register load. A fill with fewer than two muons goes straight to the
// result register. A full fill runs the multiply-accumulate, both magnitude
// square roots (one bit per cycle, the two roots side by side), the product
// step, the mass square root, bin choice and the bin division, the memory
// read-modify-write and the result register. When the mass falls outside the
// histogram window the division is skipped. The serial roots take most of a
// fill's time.
// After reset the count memory is cleared one entry a cycle, during which no
// request is taken. The result register frees the input side once a result
// is taken.
module dimuon_invariant_mass_histogram_core #(
  parameter int unsigned HIST_DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // muon_count[3:0], first_px, first_py, first_pz, second_px, second_py,
  // second_pz (20 bits each), read_bin[6:0], zero pad
  input  logic [dimu_pkg::IN_W-1:0]      in_tdata,
  // func
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mass_value[20:0], bin_index[27:21], bin_total[59:28], zero pad
  output logic [dimu_pkg::OUT_W-1:0]     out_tdata,
  // filled
  output logic                           out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dimu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [20:0]                    cfg_data
);
  import dimu_pkg::*;

  localparam int unsigned ADDR_W = $clog2(HIST_DEPTH);
  localparam int unsigned CAP = (HIST_DEPTH - 2 < 126) ? HIST_DEPTH - 2 : 126;

  // Configuration registers.
  logic [MASS_W-1:0] mass_low_r, mass_high_r;
  logic [BIN_W-1:0]  bins_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_low_r  <= MASS_W'(15360);
      mass_high_r <= MASS_W'(30720);
      bins_r      <= BIN_W'(100);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASS_LOW:  mass_low_r  <= cfg_data;
        REG_MASS_HIGH: mass_high_r <= cfg_data;
        REG_BINS:      bins_r      <= cfg_data[BIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Effective bin count.
  logic [BIN_W-1:0] eff_b;
  always_comb begin
    eff_b = bins_r;
    if (eff_b == '0) eff_b = BIN_W'(1);
    if (32'(eff_b) > CAP) eff_b = BIN_W'(CAP);
  end

  state_t state_r;
  logic [ADDR_W:0] clr_r;
  logic [3:0]  step_r;
  logic [5:0]  it_r;
  logic        func_r;
  logic signed [MOM_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [2*MOM_W-1:0] pr_r;
  logic [SQ_W-1:0] s0_r, s1_r;
  logic signed [SQ_W:0] dot_r;
  // Serial root registers for the two magnitudes and the mass.
  logic [RAD_W-1:0] x0_r, x1_r, r0_r, r1_r, bit_r;
  logic [MASS_W+1:0] mr_r;
  logic [BIN_W+MASS_W-1:0] num_r;
  logic [MASS_W-1:0] den_r;
  logic [BIN_W-1:0] q_r;
  logic [BIN_W-1:0] idx_r;
  logic [CNT_W-1:0] tot_r;
  logic             fill_r;
  logic             full_r;
  logic [2:0]       rmw_r;

  // Count memory with registered read.
  logic [CNT_W-1:0] mem [HIST_DEPTH];
  logic [CNT_W-1:0] rd_r;
  logic [ADDR_W-1:0] raddr, waddr;
  logic [CNT_W-1:0]  wdata;
  logic              we;
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  assign in_tready = (state_r == ST_IDLE) && !full_r;
  assign out_tvalid = full_r;

  // Magnitude root step logic.
  function automatic logic [2*RAD_W-1:0] rstep(logic [RAD_W-1:0] x, logic [RAD_W-1:0] r,
                                               logic [RAD_W-1:0] b);
    logic [RAD_W-1:0] xn, rn;
    if (x >= r + b) begin
      xn = x - (r + b);
      rn = (r >> 1) + b;
    end else begin
      xn = x;
      rn = r >> 1;
    end
    return {xn, rn};
  endfunction

  logic [2*RAD_W-1:0] st0, st1;
  assign st0 = rstep(x0_r, r0_r, bit_r);
  assign st1 = rstep(x1_r, r1_r, bit_r);

  logic [MASS_W-1:0] dlt;
  assign dlt = mr_r[MASS_W-1:0] - mass_low_r;
  // Divisor aligned to the quotient bit under test, most significant first.
  logic [BIN_W+MASS_W:0] trial;
  assign trial = {1'b0, num_r} - ({1'b0, den_r, {BIN_W{1'b0}}} >> (it_r[2:0] + 3'd1));

  always_comb begin
    raddr = ADDR_W'(idx_r);
    waddr = (state_r == ST_CLEAR) ? clr_r[ADDR_W-1:0] : ADDR_W'(idx_r);
    wdata = (state_r == ST_CLEAR) ? '0 : ((rd_r == CNT_MAX) ? rd_r : rd_r + 1'b1);
    we    = (state_r == ST_CLEAR) || (state_r == ST_RMW && rmw_r == 3'd1 && fill_r);
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      full_r  <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) full_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == (ADDR_W+1)'(HIST_DEPTH - 1)) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_tvalid && in_tready) begin
            func_r <= in_tuser;
            ax_r <= in_tdata[4 +: MOM_W];   ay_r <= in_tdata[24 +: MOM_W];
            az_r <= in_tdata[44 +: MOM_W];  bx_r <= in_tdata[64 +: MOM_W];
            by_r <= in_tdata[84 +: MOM_W];  bz_r <= in_tdata[104 +: MOM_W];
            step_r <= '0;
            s0_r <= '0; s1_r <= '0; dot_r <= '0;
            mr_r <= '0;
            rmw_r <= '0;
            if (in_tuser == FUNC_READ) begin
              idx_r  <= in_tdata[124 +: BIN_W];
              fill_r <= 1'b0;
              state_r <= ST_RMW;
            end else if (in_tdata[3:0] < 4'd2) begin
              idx_r <= '0; fill_r <= 1'b0; tot_r <= '0;
              state_r <= ST_OUT;
            end else begin
              fill_r <= 1'b1;
              state_r <= ST_MUL;
            end
          end
        end
        // One product per cycle over nine products.
        ST_MUL: begin
          step_r <= step_r + 1'b1;
          case (step_r)
            4'd0: pr_r <= ax_r * ax_r;
            4'd1: begin s0_r <= s0_r + SQ_W'(pr_r); pr_r <= ay_r * ay_r; end
            4'd2: begin s0_r <= s0_r + SQ_W'(pr_r); pr_r <= az_r * az_r; end
            4'd3: begin s0_r <= s0_r + SQ_W'(pr_r); pr_r <= bx_r * bx_r; end
            4'd4: begin s1_r <= s1_r + SQ_W'(pr_r); pr_r <= by_r * by_r; end
            4'd5: begin s1_r <= s1_r + SQ_W'(pr_r); pr_r <= bz_r * bz_r; end
            4'd6: begin s1_r <= s1_r + SQ_W'(pr_r); pr_r <= ax_r * bx_r; end
            4'd7: begin dot_r <= dot_r + (SQ_W+1)'(pr_r); pr_r <= ay_r * by_r; end
            4'd8: begin dot_r <= dot_r + (SQ_W+1)'(pr_r); pr_r <= az_r * bz_r; end
            default: begin
              dot_r <= dot_r + (SQ_W+1)'(pr_r);
              x0_r <= RAD_W'(s0_r); x1_r <= RAD_W'(s1_r);
              r0_r <= '0; r1_r <= '0;
              bit_r <= RAD_W'(1) << 42;
              state_r <= ST_SQRT;
            end
          endcase
        end
        // Both magnitude roots, one result bit per cycle.
        ST_SQRT: begin
          x0_r <= st0[2*RAD_W-1:RAD_W]; r0_r <= st0[RAD_W-1:0];
          x1_r <= st1[2*RAD_W-1:RAD_W]; r1_r <= st1[RAD_W-1:0];
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            step_r <= '0;
            state_r <= ST_PROD;
          end
        end
        // Magnitude product minus the dot product, doubled and floored at zero.
        ST_PROD: begin
          step_r <= step_r + 1'b1;
          if (step_r == 4'd0) begin
            pr_r <= signed'((2*MOM_W)'(r0_r[MAG_W-1:0]) * (2*MOM_W)'(r1_r[MAG_W-1:0]));
          end else begin
            x0_r <= ($signed({2'b0, pr_r}) - $signed(RAD_W'(dot_r)) > 0) ?
                    RAD_W'($signed({2'b0, pr_r}) - $signed(RAD_W'(dot_r))) << 1 : '0;
            r0_r <= '0;
            bit_r <= RAD_W'(1) << 62;
            state_r <= ST_MSQRT;
          end
        end
        // Mass root, one bit per cycle.
        ST_MSQRT: begin
          x0_r <= st0[2*RAD_W-1:RAD_W]; r0_r <= st0[RAD_W-1:0];
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            mr_r <= (st0[RAD_W-1:0] > RAD_W'(MASS_MAX)) ? {2'b0, MASS_MAX} :
                    st0[MASS_W+1:0];
            state_r <= ST_DIV;
            step_r <= '0;
          end
        end
        // Bin choice and restoring division, one quotient bit per cycle.
        ST_DIV: begin
          if (step_r == 4'd0) begin
            step_r <= 4'd1;
            it_r <= '0;
            q_r <= '0;
            num_r <= eff_b * dlt;
            den_r <= mass_high_r - mass_low_r;
            if (mr_r[MASS_W-1:0] < mass_low_r) begin
              idx_r <= '0; state_r <= ST_RMW;
            end else if (mass_high_r <= mass_low_r || mr_r[MASS_W-1:0] >= mass_high_r) begin
              idx_r <= eff_b + 1'b1; state_r <= ST_RMW;
            end
          end else begin
            it_r <= it_r + 1'b1;
            if (!trial[BIN_W+MASS_W]) begin
              num_r <= trial[BIN_W+MASS_W-1:0];
              q_r <= q_r | (BIN_W'(1) << (BIN_W - 1 - it_r[2:0]));
            end
            if (it_r == 6'(BIN_W - 1)) begin
              idx_r <= (trial[BIN_W+MASS_W] ? q_r :
                        q_r | BIN_W'(1)) + 1'b1;
              state_r <= ST_RMW;
            end
          end
        end
        // Read the bin count and, for a fill, increment it (saturating) and write it back.
        ST_RMW: begin
          rmw_r <= rmw_r + 1'b1;
          if (rmw_r == 3'd1) begin
            if (32'(idx_r) >= HIST_DEPTH) tot_r <= '0;
            else tot_r <= fill_r ? wdata : rd_r;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!full_r) begin
            full_r <= 1'b1;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result register payload.
  logic [MASS_W-1:0] mass_out;
  assign mass_out = (func_r == FUNC_READ || !fill_r) ? '0 : mr_r[MASS_W-1:0];
  assign out_tdata = {4'b0, tot_r, idx_r, mass_out};
  assign out_tuser = fill_r;
endmodule

// ----- sv/dimu_checker.sv -----
// Port-level checker for the histogram core and its bind.
`include "dimuon_invariant_mass_histogram_core_defines.svh"
module dimu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);
  // One request at a time: no new request while a result waits.
  `DIMU_ASSERT_IMPL(no_in_while_out, out_tvalid, !in_tready)
  // An accepted request is followed by a busy input side.
  `DIMU_ASSERT_NEXT(busy_after_req, in_tvalid && in_tready, !in_tready)
  // A result with no fill reports zero mass.
  `DIMU_ASSERT_IMPL(nofill_zero_mass, out_tvalid && !out_tuser, out_tdata[20:0] == 21'd0)
  // A fill result never reports an empty bin.
  `DIMU_ASSERT_IMPL(fill_nonzero, out_tvalid && out_tuser, out_tdata[59:28] != 32'd0)
endmodule

bind dimuon_invariant_mass_histogram_core dimu_checker u_dimu_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);

// ----- dv/dimuon_invariant_mass_histogram_checker.sv -----
// Checker that predicts and compares the results of the dimuon mass histogram core.
module dimuon_invariant_mass_histogram_checker #(
  parameter int unsigned HIST_DEPTH = 128
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [dimu_pkg::IN_W-1:0]      in_tdata,
  input  logic                           in_tuser,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [dimu_pkg::OUT_W-1:0]     out_tdata,
  input  logic                           out_tuser,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [dimu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [20:0]                    cfg_data,
  output int unsigned                    error_count,
  output int unsigned                    results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import dimu_pkg::*;

  typedef struct packed {
    logic [MASS_W-1:0] mass_value;
    logic [BIN_W-1:0]  bin_index;
    logic              filled;
    logic [CNT_W-1:0]  bin_total;
  } mass_result_t;

  mass_result_t      expected_results[$];
  logic [CNT_W-1:0]  bin_counts[HIST_DEPTH];
  logic [MASS_W-1:0] low_edge;
  logic [MASS_W-1:0] high_edge;
  logic [BIN_W-1:0]  bins_reg;

  assign results_owed = expected_results.size();

  // Integer square root, rounded down.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitval;
    root = 0;
    bitval = 64'd1 << 62;
    while (bitval > x) bitval >>= 2;
    while (bitval != 0) begin
      if (x >= root + bitval) begin
        x -= root + bitval;
        root = (root >> 1) + bitval;
      end else begin
        root >>= 1;
      end
      bitval >>= 2;
    end
    return root;
  endfunction

  // Works out the result of one request and updates the count copy.
  function automatic mass_result_t predict_event(logic [IN_W-1:0] d, logic func);
    mass_result_t   r;
    longint         ax, ay, az, bx, by, bz, dot, diff;
    longint unsigned mag0, mag1, mass, nbins, cap;
    int unsigned    idx;
    r = '0;
    if (func == FUNC_READ) begin
      r.bin_index = d[130:124];
      r.bin_total = (d[130:124] < HIST_DEPTH) ? bin_counts[d[130:124]] : '0;
      return r;
    end
    if (d[3:0] < 2) return r;
    ax = $signed(d[23:4]);    ay = $signed(d[43:24]);   az = $signed(d[63:44]);
    bx = $signed(d[83:64]);   by = $signed(d[103:84]);  bz = $signed(d[123:104]);
    mag0 = floor_sqrt(ax * ax + ay * ay + az * az);
    mag1 = floor_sqrt(bx * bx + by * by + bz * bz);
    dot = ax * bx + ay * by + az * bz;
    diff = longint'(mag0 * mag1) - dot;
    mass = (diff > 0) ? floor_sqrt(64'(diff) * 2) : 64'd0;
    if (mass > 64'(MASS_MAX)) mass = 64'(MASS_MAX);
    // Effective bin count is forced into one..cap.
    cap = 64'((HIST_DEPTH - 2 < 126) ? HIST_DEPTH - 2 : 126);
    nbins = (bins_reg == '0) ? 64'd1 : 64'(bins_reg);
    if (nbins > cap) nbins = cap;
    if (mass < 64'(low_edge)) begin
      idx = 0;
    end else if (high_edge <= low_edge || mass >= 64'(high_edge)) begin
      idx = 32'(nbins + 64'd1);
    end else begin
      idx = 32'(64'd1 + (nbins * (mass - 64'(low_edge))) /
                (64'(high_edge) - 64'(low_edge)));
    end
    if (bin_counts[idx] != CNT_MAX) bin_counts[idx] = bin_counts[idx] + 1'b1;
    r.mass_value = MASS_W'(mass);
    r.bin_index = BIN_W'(idx);
    r.filled = 1'b1;
    r.bin_total = bin_counts[idx];
    return r;
  endfunction

  // Track register writes and requests, then compare each result.
  always @(posedge clk) begin
    mass_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) bin_counts[i] = '0;
      low_edge = 21'd15360;
      high_edge = 21'd30720;
      bins_reg = 7'd100;
      error_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MASS_LOW:  low_edge = cfg_data;
          REG_MASS_HIGH: high_edge = cfg_data;
          REG_BINS:      bins_reg = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_results.push_back(predict_event(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", out_tdata);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[20:0] !== want.mass_value) begin
            $error("mass_value expected %0d actual %0d", want.mass_value, out_tdata[20:0]);
            error_count++;
          end
          if (out_tdata[27:21] !== want.bin_index) begin
            $error("bin_index expected %0d actual %0d", want.bin_index, out_tdata[27:21]);
            error_count++;
          end
          if (out_tuser !== want.filled) begin
            $error("filled expected %0d actual %0d", want.filled, out_tuser);
            error_count++;
          end
          if (out_tdata[59:28] !== want.bin_total) begin
            $error("bin_total expected %0d actual %0d", want.bin_total, out_tdata[59:28]);
            error_count++;
          end
        end
      end
    end
  end
endmodule

// ----- dv/dimuon_invariant_mass_histogram_core_tb.sv -----
// Testbench top: drives events, reads and register writes into the histogram core.
module dimuon_invariant_mass_histogram_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dimu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 in_tuser = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [20:0]          cfg_data = '0;
  int unsigned          error_count;
  int unsigned          results_owed;
  int unsigned          cycle_count = 0;
  bit                   no_gaps = 1'b0;

  always #4 clk = ~clk;

  dimuon_invariant_mass_histogram_core DUT (.*);

  dimuon_invariant_mass_histogram_checker checker_i (.*);

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 5);
  endfunction

  // Result side: random stalls between taken results.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Sends one request after a random gap; valid stays high when no gap follows.
  task automatic send_request(logic func, logic [3:0] muons, logic [19:0] mom[6],
                              logic [6:0] rbin);
    logic [IN_W-1:0] d;
    int unsigned gap;
    d = '0;
    d[3:0] = muons;
    for (int i = 0; i < 6; i++) d[4 + 20 * i +: 20] = mom[i];
    d[130:124] = rbin;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= func;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_fill(logic [3:0] muons, int a0, int a1, int a2,
                           int b0, int b1, int b2);
    logic [19:0] mom[6];
    mom = '{a0[19:0], a1[19:0], a2[19:0], b0[19:0], b1[19:0], b2[19:0]};
    send_request(FUNC_FILL, muons, mom, 7'($urandom));
  endtask

  task automatic send_read(logic [6:0] rbin);
    logic [19:0] mom[6];
    foreach (mom[i]) mom[i] = 20'($urandom);
    send_request(FUNC_READ, 4'($urandom), mom, rbin);
  endtask

  // Holds valid high across back-to-back register writes.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [20:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Waits for the core to drain, then loads all three registers.
  task automatic set_histogram(logic [20:0] lo, logic [20:0] hi, logic [6:0] nbins);
    in_tvalid <= 1'b0;
    while (results_owed != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    write_reg(REG_MASS_LOW, lo);
    write_reg(REG_MASS_HIGH, hi);
    write_reg(REG_BINS, {14'd0, nbins});
    cfg_valid <= 1'b0;
  endtask

  // Momentum component of random magnitude, sometimes at the extremes.
  function automatic logic [19:0] rand_component();
    logic signed [19:0] v;
    int unsigned w;
    case ($urandom_range(0, 9))
      0: return 20'h7FFFF;
      1: return 20'h80000;
      2: return 20'($urandom);
      default: begin
        w = $urandom_range(8, 17);
        v = 20'($urandom);
        v = (v <<< (20 - w)) >>> (20 - w);
        return v;
      end
    endcase
  endfunction

  task automatic random_phase(int unsigned n);
    logic [19:0] mom[6];
    logic [3:0]  muons;
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_read(7'($urandom));
      end else begin
        foreach (mom[i]) mom[i] = rand_component();
        muons = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 1))
                                            : 4'($urandom_range(2, 15));
        send_request(FUNC_FILL, muons, mom, 7'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset register values.
    send_read(7'd0);
    send_read(7'd127);
    send_fill(4'd0, 1000, 2000, 3000, -1000, -2000, -3000);
    send_fill(4'd1, -524288, 524287, 0, 524287, -524288, 0);
    send_fill(4'd2, 0, 0, 0, 0, 0, 0);
    // Collinear pair: rounding makes the radicand negative.
    send_fill(4'd2, 1, 1, 0, 1, 1, 0);
    send_fill(4'd15, 524287, 524287, 524287, -524288, -524288, -524288);
    send_fill(4'd15, -524288, -524288, -524288, -524288, -524288, -524288);
    // Back-to-back pairs inside and above the window.
    send_fill(4'd2, 11520, 0, 0, -11520, 0, 0);
    send_fill(4'd3, 11520, 0, 0, -11520, 0, 0);
    send_fill(4'd2, 0, 25600, 0, 0, -25600, 0);
    send_fill(4'd2, 0, 0, 7680, 0, 0, -7680);
    send_fill(4'd2, 0, 0, 15359, 0, 0, -15359);
    send_read(7'd51);
    send_read(7'd101);
    send_read(7'd0);
    send_read(7'd1);
    send_read(7'd100);

    // Register settings, extremes among them.
    random_phase(100);
    set_histogram(21'd0, 21'h1FFFFF, 7'd126);
    no_gaps = 1'b1;
    random_phase(90);
    no_gaps = 1'b0;
    set_histogram(21'd4000, 21'd4000, 7'd0);
    random_phase(90);
    set_histogram(21'h1FFFFF, 21'd1, 7'd127);
    random_phase(60);
    set_histogram(21'd2000, 21'd40000, 7'd1);
    random_phase(90);
    set_histogram(21'($urandom_range(0, 20000)), 21'($urandom_range(20001, 90000)),
                  7'($urandom_range(1, 126)));
    random_phase(100);
    in_tvalid <= 1'b0;

    while (results_owed != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
